/* sv/rpb_pkg.sv */
// Shared types, constants and helper functions of the ROM prefetch buffer.
package rpb_pkg;

  localparam int BUF_DEPTH  = 8;
  localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
  localparam int ADDR_W     = 32;
  localparam int CYC_W      = 7;
  localparam int CD_W       = 8;
  localparam int WAIT_W     = 4;
  localparam int CFG_IDX_W  = 3;

  localparam logic [ADDR_W-1:0] ROM_LOW  = 32'h0800_0000;
  localparam logic [ADDR_W-1:0] ROM_HIGH = 32'h0EFF_FFFF;

  // Input operation codes
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_IDLE   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PREFETCH_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WS0_SEQ_CYCLES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WS1_SEQ_CYCLES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WS2_SEQ_CYCLES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_E_CYCLES = 3'd4;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CYC_W-1:0]     cyc_t;
  typedef logic [CD_W-1:0]      cd_t;
  typedef logic [WAIT_W-1:0]    wait_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef struct packed {
    logic  prefetch_enable;
    wait_t ws0_seq_cycles;
    wait_t ws1_seq_cycles;
    wait_t ws2_seq_cycles;
    wait_t region_e_cycles;
  } cfg_t;

  // Control broadcast from the controller to every buffer cell
  typedef struct packed {
    logic  upd;       // a transaction is taken this cycle
    logic  wr;        // start a fetch: write next into slot count
    logic  shift;     // drop the head, move entries toward slot 0
    cnt_t  count;     // current entry count
    cnt_t  capacity;  // entries usable in the current instruction state
    addr_t probe;     // effective access address
    addr_t next;      // address of the fetch being started
  } cell_ctl_t;

  // Status gathered from the cells
  typedef struct packed {
    logic  match;     // probe equals the entry at slot count
    addr_t base;      // entry at slot count-1
    addr_t head;      // slot 0 after a possible write
  } cell_stat_t;

  function automatic logic in_rom(input addr_t a);
    in_rom = (a >= ROM_LOW) && (a <= ROM_HIGH);
  endfunction

  function automatic cd_t seq_cost(input addr_t a, input logic thumb, input cfg_t cfg);
    logic [3:0] region;
    cd_t        c;
    region = a[27:24];
    c      = '0;
    priority if (region == 4'd8 || region == 4'd9) begin
      c = cd_t'(cfg.ws0_seq_cycles);
    end else if (region == 4'd10 || region == 4'd11) begin
      c = cd_t'(cfg.ws1_seq_cycles);
    end else if (region == 4'd12 || region == 4'd13) begin
      c = cd_t'(cfg.ws2_seq_cycles);
    end else if (region >= 4'd14) begin
      return cd_t'(cfg.region_e_cycles);
    end else begin
      return cd_t'(1);
    end
    seq_cost = thumb ? c : cd_t'(c << 1);
  endfunction

endpackage

/* sv/rpb_cell.sv */
// One slot of the prefetch buffer: holds an opcode address, compares and shifts.
module rpb_cell (
  input  logic               clk,
  input  logic               rst,
  input  rpb_pkg::cnt_t      slot,
  input  rpb_pkg::cell_ctl_t ctl,
  input  rpb_pkg::addr_t     from_right,
  output rpb_pkg::addr_t     post,
  output logic               match,
  output rpb_pkg::addr_t     base_part
);
  import rpb_pkg::*;

  addr_t entry;
  cnt_t  slot_up;
  logic  take_right;

  assign slot_up    = cnt_t'(slot + cnt_t'(1));
  assign post       = (ctl.wr && (slot == ctl.count)) ? ctl.next : entry;
  assign match      = (slot == ctl.count) && (ctl.probe == entry);
  assign base_part  = (slot_up == ctl.count) ? entry : '0;
  assign take_right = ctl.shift && (slot_up < ctl.capacity);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (ctl.upd) begin
      entry <= take_right ? from_right : post;
    end
  end

endmodule

/* sv/rpb_ctrl.sv */
// Fetch state, decisions and cycle accounting of the prefetch buffer.
module rpb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                op,
  input  rpb_pkg::addr_t      address,
  input  rpb_pkg::addr_t      pc,
  input  logic                thumb,
  input  rpb_pkg::cyc_t       access_cycles,
  input  rpb_pkg::cfg_t       cfg,
  input  rpb_pkg::cell_stat_t stat,
  output rpb_pkg::cell_ctl_t  ctl,
  output rpb_pkg::cyc_t       res_cycles,
  output logic                res_hit
);
  import rpb_pkg::*;

  logic  fetch_active, fetch_active_next;
  cnt_t  entry_count, entry_count_next;
  cd_t   fetch_countdown, fetch_countdown_next;
  addr_t last_rom_address, last_rom_address_next;

  logic  idle_plain, wait_hit, start, shift;
  addr_t probe, base, next_addr;
  cyc_t  cyc;
  cnt_t  capacity;
  logic  act1;
  cd_t   cd1;
  cnt_t  cnt1;
  cyc_t  c1;
  logic  hit;

  always_comb begin
    idle_plain = op & ~cfg.prefetch_enable;
    probe      = op ? '0 : address;
    cyc        = op ? cyc_t'(1) : access_cycles;
    capacity   = thumb ? cnt_t'(BUF_DEPTH) : cnt_t'(BUF_DEPTH / 2);
    wait_hit   = ~idle_plain & fetch_active & stat.match;
    start      = ~idle_plain & ~wait_hit & ~fetch_active & (entry_count < capacity)
               & in_rom(pc) & ~in_rom(probe) & (pc == last_rom_address);
    base       = (entry_count != '0) ? stat.base : pc;
    next_addr  = base + (thumb ? addr_t'(2) : addr_t'(4));

    act1  = fetch_active;
    cd1   = fetch_countdown;
    cnt1  = entry_count;
    c1    = cyc;
    hit   = 1'b0;
    shift = 1'b0;

    fetch_active_next     = fetch_active;
    entry_count_next      = entry_count;
    fetch_countdown_next  = fetch_countdown;
    last_rom_address_next = last_rom_address;

    if (wait_hit) begin
      // Wait out the in-flight fetch; its slot fills and the head drops
      fetch_active_next     = 1'b0;
      fetch_countdown_next  = '0;
      last_rom_address_next = probe;
      c1                    = fetch_countdown[CYC_W-1:0];
      shift                 = 1'b1;
    end else begin
      if (!idle_plain) begin
        if (fetch_active && in_rom(probe)) act1 = 1'b0;
        if (start) begin
          act1 = 1'b1;
          cd1  = seq_cost(next_addr, thumb, cfg);
        end
        if (in_rom(probe)) last_rom_address_next = probe;
        if (probe == pc) begin
          if (probe == stat.head) begin
            c1    = cyc_t'(1);
            hit   = 1'b1;
            shift = 1'b1;
            if (cnt1 != '0) cnt1 = cnt1 - cnt_t'(1);
          end else begin
            act1 = 1'b0;
            cnt1 = '0;
          end
        end
      end
      // Advance the pending fetch by the cycles spent
      if (act1) begin
        if (cd_t'(c1) >= cd1) begin
          cd1  = '0;
          act1 = 1'b0;
          if (cnt1 < cnt_t'(BUF_DEPTH)) cnt1 = cnt1 + cnt_t'(1);
        end else begin
          cd1 = cd1 - cd_t'(c1);
        end
      end
      fetch_active_next    = act1;
      fetch_countdown_next = cd1;
      entry_count_next     = cnt1;
    end

    res_cycles = c1;
    res_hit    = hit;

    ctl.upd      = accept;
    ctl.wr       = start;
    ctl.shift    = shift;
    ctl.count    = entry_count;
    ctl.capacity = capacity;
    ctl.probe    = probe;
    ctl.next     = next_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_active     <= 1'b0;
      entry_count      <= '0;
      fetch_countdown  <= '0;
      last_rom_address <= '0;
    end else if (accept) begin
      fetch_active     <= fetch_active_next;
      entry_count      <= entry_count_next;
      fetch_countdown  <= fetch_countdown_next;
      last_rom_address <= last_rom_address_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= cnt_t'(BUF_DEPTH))
    else $error("entry count above buffer depth");

  a_wait_ends_fetch: assert property (@(posedge clk) disable iff (rst)
    accept && wait_hit |=> !fetch_active)
    else $error("fetch still active after waiting on it");

  a_plain_idle_keeps_rom: assert property (@(posedge clk) disable iff (rst)
    accept && idle_plain |=> $stable(last_rom_address))
    else $error("plain idle cycle changed last ROM address");

endmodule

/* sv/rom_prefetch_buffer.sv */
// Top level of the cartridge ROM prefetch buffer: config, cell chain, result register.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  op, address, pc, thumb, access_cycles
//   out      output     out_valid/out_stall  consumed_cycles, buffer_hit
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// One transaction per clock unless in_stall is high: the whole decision, the cell
// compares and the buffer shift finish in the cycle the transaction is taken, and
// the result lands in the output register in the following cycle.
// Reset (synchronous, rst high) empties the buffer, clears every slot to zero and
// loads the register defaults; no clearing pass is needed.
// The input stalls only while the output register is full and out_stall is high.
module rom_prefetch_buffer (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_write,
  input  rpb_pkg::cfg_idx_t         cfg_index,
  input  rpb_pkg::wait_t            cfg_data,
  // input transactions
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  rpb_pkg::addr_t            address,
  input  rpb_pkg::addr_t            pc,
  input  logic                      thumb,
  input  rpb_pkg::cyc_t             access_cycles,
  // result transactions
  output logic                      out_valid,
  input  logic                      out_stall,
  output rpb_pkg::cyc_t             consumed_cycles,
  output logic                      buffer_hit
);
  import rpb_pkg::*;

  cfg_t       cfg;
  cell_ctl_t  ctl;
  cell_stat_t stat;
  logic       accept;
  cyc_t       res_cycles;
  logic       res_hit;

  addr_t cell_post [BUF_DEPTH];
  addr_t cell_base [BUF_DEPTH];
  logic  cell_match[BUF_DEPTH];

  // Hold a new transaction only while the result register is full and blocked
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prefetch_enable <= 1'b0;
      cfg.ws0_seq_cycles  <= wait_t'(3);
      cfg.ws1_seq_cycles  <= wait_t'(5);
      cfg.ws2_seq_cycles  <= wait_t'(9);
      cfg.region_e_cycles <= wait_t'(5);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PREFETCH_ENABLE: cfg.prefetch_enable <= cfg_data[0];
        REG_WS0_SEQ_CYCLES:  cfg.ws0_seq_cycles  <= cfg_data;
        REG_WS1_SEQ_CYCLES:  cfg.ws1_seq_cycles  <= cfg_data;
        REG_WS2_SEQ_CYCLES:  cfg.ws2_seq_cycles  <= cfg_data;
        REG_REGION_E_CYCLES: cfg.region_e_cycles <= cfg_data;
        default: ;
      endcase
    end
  end

  rpb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .op            (op),
    .address       (address),
    .pc            (pc),
    .thumb         (thumb),
    .access_cycles (access_cycles),
    .cfg           (cfg),
    .stat          (stat),
    .ctl           (ctl),
    .res_cycles    (res_cycles),
    .res_hit       (res_hit)
  );

  // Row of buffer slots; on a shift each slot below capacity-1 takes its right neighbor's entry
  for (genvar g = 0; g < BUF_DEPTH; g++) begin : g_cell
    addr_t right;
    if (g == BUF_DEPTH - 1) begin : g_last
      assign right = cell_post[g];
    end else begin : g_mid
      assign right = cell_post[g + 1];
    end
    rpb_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .slot       (cnt_t'(g)),
      .ctl        (ctl),
      .from_right (right),
      .post       (cell_post[g]),
      .match      (cell_match[g]),
      .base_part  (cell_base[g])
    );
  end

  // Gather the one-hot slot results
  always_comb begin
    stat.match = 1'b0;
    stat.base  = '0;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      stat.match = stat.match | cell_match[i];
      stat.base  = stat.base | cell_base[i];
    end
    stat.head = cell_post[0];
  end

  // Result register: load on accept, drop when taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      consumed_cycles <= res_cycles;
      buffer_hit      <= res_hit;
    end
  end

  a_hit_costs_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && buffer_hit |-> consumed_cycles == cyc_t'(1))
    else $error("buffer hit with cost other than one cycle");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction left no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(consumed_cycles) && $stable(buffer_hit))
    else $error("stalled result changed or vanished");

endmodule

/* sim/rpb_timing_checker.sv */
// Checker for the ROM prefetch buffer: watches all ports, predicts each access and compares.
module rpb_timing_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  rpb_pkg::cfg_idx_t cfg_index,
  input  rpb_pkg::wait_t    cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              op,
  input  rpb_pkg::addr_t    address,
  input  rpb_pkg::addr_t    pc,
  input  logic              thumb,
  input  rpb_pkg::cyc_t     access_cycles,
  input  logic              out_valid,
  input  logic              out_stall,
  input  rpb_pkg::cyc_t     consumed_cycles,
  input  logic              buffer_hit,
  output int                errors,
  output int                pending,
  output int                hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import rpb_pkg::*;

  localparam int   MAX_LINES = 40;

  typedef struct packed {
    cyc_t cycles;
    logic hit;
  } timing_t;

  // Register copies
  logic  pf_enable;
  int    ws0_cost, ws1_cost, ws2_cost, region_e_cost;

  // Buffer state
  logic  pf_active;
  int    pf_count;
  int    pf_countdown;
  addr_t pf_slot [BUF_DEPTH];
  addr_t last_rom;

  timing_t expected_timing [$];
  timing_t got_timing;
  timing_t want_timing;

  task automatic report(input string msg);
    if (errors < MAX_LINES) begin
      $display("[%0t] timing mismatch: %s", $time, msg);
    end
    errors++;
  endtask

  function automatic logic is_rom(input addr_t a);
    return a >= ROM_LOW && a <= ROM_HIGH;
  endfunction

  function automatic int fetch_cost(input addr_t a, input logic th);
    int c;
    case (a[27:24])
      4'h8, 4'h9: c = ws0_cost;
      4'hA, 4'hB: c = ws1_cost;
      4'hC, 4'hD: c = ws2_cost;
      4'hE, 4'hF: return region_e_cost;
      default:    return 1;
    endcase
    return th ? c : 2 * c;
  endfunction

  task automatic reset_model();
    pf_enable     = 1'b0;
    ws0_cost      = 3;
    ws1_cost      = 5;
    ws2_cost      = 9;
    region_e_cost = 5;
    pf_active     = 1'b0;
    pf_count      = 0;
    pf_countdown  = 0;
    last_rom      = '0;
    foreach (pf_slot[i]) pf_slot[i] = '0;
  endtask

  // Charge c against the pending fetch's countdown; a finished fetch adds one entry.
  task automatic advance_fetch(input int c);
    if (pf_active) begin
      if (c >= pf_countdown) begin
        pf_countdown = 0;
        pf_active    = 1'b0;
        if (pf_count < BUF_DEPTH) pf_count++;
      end else begin
        pf_countdown -= c;
      end
    end
  endtask

  task automatic drop_head(input int cap);
    if (pf_count > 0) pf_count--;
    for (int i = 1; i < cap && i < BUF_DEPTH; i++) pf_slot[i-1] = pf_slot[i];
  endtask

  task automatic predict_timing(input logic op_i, input addr_t addr_i, input addr_t pc_i,
                                input logic th_i, input cyc_t cyc_i, output timing_t res);
    addr_t a;
    addr_t base;
    addr_t nxt;
    int    cyc;
    int    cap;
    int    spent;
    logic  hit;
    a   = addr_i;
    cyc = int'(cyc_i);
    cap = th_i ? BUF_DEPTH : BUF_DEPTH / 2;
    hit = 1'b0;
    if (op_i == OP_IDLE) begin
      if (!pf_enable) begin
        advance_fetch(1);
        res = '{cycles: cyc_t'(1), hit: 1'b0};
        return;
      end
      a   = '0;
      cyc = 1;
    end
    if (pf_active) begin
      // Stall on the entry still being fetched
      if (pf_count < BUF_DEPTH) begin
        if (a == pf_slot[pf_count]) begin
          spent = pf_countdown;
          advance_fetch(spent);
          drop_head(cap);
          last_rom = a;
          res = '{cycles: cyc_t'(spent), hit: 1'b0};
          return;
        end
      end
      if (is_rom(a)) pf_active = 1'b0;
    end else if (pf_count < cap && is_rom(pc_i) && !is_rom(a) && pc_i == last_rom) begin
      if (pf_count > 0) base = pf_slot[pf_count-1];
      else              base = pc_i;
      nxt = base + (th_i ? 32'd2 : 32'd4);
      pf_active         = 1'b1;
      pf_slot[pf_count] = nxt;
      pf_countdown      = fetch_cost(nxt, th_i);
    end
    if (is_rom(a)) last_rom = a;
    if (a == pc_i) begin
      if (a == pf_slot[0]) begin
        cyc = 1;
        hit = 1'b1;
        drop_head(cap);
      end else begin
        pf_active = 1'b0;
        pf_count  = 0;
      end
    end
    advance_fetch(cyc);
    res = '{cycles: cyc_t'(cyc), hit: hit};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      expected_timing.delete();
      errors = 0;
      hits   = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PREFETCH_ENABLE: pf_enable     = cfg_data[0];
          REG_WS0_SEQ_CYCLES:  ws0_cost      = int'(cfg_data);
          REG_WS1_SEQ_CYCLES:  ws1_cost      = int'(cfg_data);
          REG_WS2_SEQ_CYCLES:  ws2_cost      = int'(cfg_data);
          REG_REGION_E_CYCLES: region_e_cost = int'(cfg_data);
          default: ;
        endcase
      end
      // Retire first: a result never belongs to the transaction taken at the same edge
      if (out_valid && !out_stall) begin
        got_timing = '{cycles: consumed_cycles, hit: buffer_hit};
        if (expected_timing.size() == 0) begin
          report($sformatf("result cycles %0d hit %0b with nothing outstanding",
                           consumed_cycles, buffer_hit));
        end else begin
          want_timing = expected_timing.pop_front();
          if (got_timing.cycles !== want_timing.cycles) begin
            report($sformatf("consumed_cycles %0d, expected %0d",
                             got_timing.cycles, want_timing.cycles));
          end
          if (got_timing.hit !== want_timing.hit) begin
            report($sformatf("buffer_hit %0b, expected %0b", got_timing.hit, want_timing.hit));
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_timing(op, address, pc, thumb, access_cycles, want_timing);
        if (want_timing.hit) hits++;
        expected_timing.push_back(want_timing);
      end
    end
    pending = expected_timing.size();
  end

endmodule

/* sim/tb.sv */
// Testbench top for the ROM prefetch buffer: clock, reset, stimulus, random stalls and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rpb_pkg::*;

  // Items per random phase; six phases give roughly 900 transactions.
  localparam int   PHASE_ITEMS = 150;
  localparam int   PHASES      = 6;
  // Sized for the worst case with both sides idling their longest random gaps,
  // so this leaves ample margin over ~950 transactions plus config and drains.
  localparam int   CYCLE_LIMIT = 300_000;
  // First register index the block does not decode.
  localparam cfg_idx_t REG_UNDECODED = REG_REGION_E_CYCLES + 3'd1;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_write = 1'b0;
  cfg_idx_t cfg_index = '0;
  wait_t    cfg_data = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  logic     op = OP_ACCESS;
  addr_t    address = '0;
  addr_t    pc = '0;
  logic     thumb = 1'b0;
  cyc_t     access_cycles = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cyc_t     consumed_cycles;
  logic     buffer_hit;

  int       errors;
  int       pending;
  int       hits;
  int       items_sent = 0;
  int       settings = 0;
  int       cycle_count = 0;
  // While set, the matching side never idles: gives back-to-back stretches.
  logic     send_calm = 1'b0;
  logic     take_calm = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  rom_prefetch_buffer i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .address         (address),
    .pc              (pc),
    .thumb           (thumb),
    .access_cycles   (access_cycles),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .consumed_cycles (consumed_cycles),
    .buffer_hit      (buffer_hit)
  );

  rpb_timing_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .address         (address),
    .pc              (pc),
    .thumb           (thumb),
    .access_cycles   (access_cycles),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .consumed_cycles (consumed_cycles),
    .buffer_hit      (buffer_hit),
    .errors          (errors),
    .pending         (pending),
    .hits            (hits)
  );

  // Hard stop: a lost or stuck result shows up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("rom_prefetch_buffer test failed");
      $finish;
    end
  end

  // Result side: hold stall for a random count, then take exactly one transaction.
  // Sample out_valid mid-cycle so the decision never races the edge.
  initial begin : result_sink
    int   hold;
    logic seen;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
      hold = take_calm ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        seen = out_valid;
        @(posedge clk);
      end while (!seen);
    end
  end

  // Drive one transaction: drop valid for a random gap, present the payload,
  // hold it until the edge at which in_stall is low.
  task automatic send_item(input logic o, input addr_t a, input addr_t p, input logic th,
                           input cyc_t c);
    int   gap;
    logic stalled;
    gap = send_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= o;
    address       <= a;
    pc            <= p;
    thumb         <= th;
    access_cycles <= c;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    items_sent++;
  endtask

  // Drop valid and wait until every outstanding result has been taken.
  task automatic settle();
    logic busy;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      busy = (pending != 0);
      @(posedge clk);
    end while (busy);
    // Extra idle clocks leave the block fully quiet.
    repeat (2) @(posedge clk);
  endtask

  // Write every register, plus one index the block must ignore.
  // The upper data bits of the enable write are random: only bit 0 counts.
  task automatic program_config(input logic en, input wait_t w0, input wait_t w1,
                                input wait_t w2, input wait_t w3);
    cfg_idx_t idx [6];
    wait_t    val [6];
    idx = '{REG_PREFETCH_ENABLE, REG_WS0_SEQ_CYCLES, REG_WS1_SEQ_CYCLES,
            REG_WS2_SEQ_CYCLES, REG_REGION_E_CYCLES,
            cfg_idx_t'($urandom_range(REG_UNDECODED, {CFG_IDX_W{1'b1}}))};
    val = '{{3'($urandom), en}, w0, w1, w2, w3, wait_t'($urandom)};
    for (int k = 0; k < 6; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    settings++;
  endtask

  function automatic addr_t rom_addr(input logic th);
    addr_t a;
    if ($urandom_range(0, 7) == 0) begin
      a = ROM_HIGH - $urandom_range(0, 63);
    end else begin
      a = {4'h0, 4'($urandom_range(8, 14)), 24'($urandom)};
    end
    return th ? {a[31:1], 1'b0} : {a[31:2], 2'b00};
  endfunction

  // Data addresses that miss ROM: low regions, the region just above ROM, far high, zero.
  function automatic addr_t outside_rom();
    case ($urandom_range(0, 3))
      0:       return {4'h0, 4'($urandom_range(0, 7)), 24'($urandom)};
      1:       return {8'h0F, 24'($urandom)};
      2:       return {4'($urandom_range(1, 15)), 28'($urandom)};
      default: return '0;
    endcase
  endfunction

  function automatic cyc_t draw_cycles();
    if ($urandom_range(0, 7) == 0) return cyc_t'($urandom_range(0, 127));
    return cyc_t'($urandom_range(0, 6));
  endfunction

  // Program-like stream: sequential opcode fetches with data accesses and idle
  // cycles in between (the only pattern that lets prefetches start), plus
  // branches, state switches, aborting ROM data reads and raw noise.
  task automatic run_program(input int n);
    addr_t pc_now;
    logic  th_now;
    int    pick;
    th_now = 1'($urandom_range(0, 1));
    pc_now = rom_addr(th_now);
    send_item(OP_ACCESS, pc_now, pc_now, th_now, draw_cycles());
    for (int k = 1; k < n; k++) begin
      if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        pc_now = pc_now + (th_now ? 32'd2 : 32'd4);
        if (pc_now > ROM_HIGH - 8) pc_now = rom_addr(th_now);
        send_item(OP_ACCESS, pc_now, pc_now, th_now, draw_cycles());
      end else if (pick < 62) begin
        send_item(OP_ACCESS, outside_rom(), pc_now, th_now, draw_cycles());
      end else if (pick < 80) begin
        send_item(OP_IDLE, $urandom, pc_now, th_now, draw_cycles());
      end else if (pick < 85) begin
        send_item(OP_ACCESS, rom_addr(th_now), pc_now, th_now, draw_cycles());
      end else if (pick < 90) begin
        pc_now = rom_addr(th_now);
        send_item(OP_ACCESS, pc_now, pc_now, th_now, draw_cycles());
      end else if (pick < 94) begin
        th_now = !th_now;
        pc_now = {pc_now[31:2], 2'b00};
        send_item(OP_ACCESS, pc_now, pc_now, th_now, draw_cycles());
      end else begin
        send_item(1'($urandom_range(0, 1)), $urandom, $urandom, 1'($urandom_range(0, 1)),
                  cyc_t'($urandom_range(0, 127)));
      end
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, prefetch off.
    // Idle without prefetch: one cycle, advances nothing else.
    send_item(OP_IDLE, 32'h0, 32'h0, 1'b1, cyc_t'(1));
    // Opcode fetch at zero hits the stale zero head with an empty count.
    send_item(OP_ACCESS, 32'h0, 32'h0, 1'b1, cyc_t'(5));
    // All-ones fields: miss that flushes the buffer.
    send_item(OP_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, cyc_t'(127));
    // Zero access cycles on a ROM opcode fetch.
    send_item(OP_ACCESS, 32'h0800_0000, 32'h0800_0000, 1'b1, cyc_t'(0));
    // Data access outside ROM starts a fetch that finishes within it, then hit.
    send_item(OP_ACCESS, 32'h0300_0000, 32'h0800_0000, 1'b1, cyc_t'(4));
    send_item(OP_ACCESS, 32'h0800_0002, 32'h0800_0002, 1'b1, cyc_t'(4));
    // Short data access, then fetch the entry still in flight.
    send_item(OP_ACCESS, 32'h0200_0000, 32'h0800_0002, 1'b1, cyc_t'(1));
    send_item(OP_ACCESS, 32'h0800_0004, 32'h0800_0004, 1'b1, cyc_t'(3));
    // 32-bit state doubles the cost; a ROM data read aborts the fetch.
    send_item(OP_ACCESS, 32'h0200_0000, 32'h0800_0004, 1'b0, cyc_t'(2));
    send_item(OP_ACCESS, 32'h0A00_0000, 32'h0800_0004, 1'b0, cyc_t'(7));
    settle();

    // Prefetch on; zero cost in regions 8/9 and C/D, full cost in A/B and E/F.
    program_config(1'b1, wait_t'(0), wait_t'(15), wait_t'(0), wait_t'(15));
    send_item(OP_ACCESS, 32'h0800_0100, 32'h0800_0100, 1'b1, cyc_t'(3));
    // Idle acts as an access to address zero; zero countdown finishes at once.
    send_item(OP_IDLE, 32'hFFFF_FFFF, 32'h0800_0100, 1'b1, cyc_t'(127));
    send_item(OP_IDLE, 32'h0, 32'h0800_0100, 1'b1, cyc_t'(9));
    send_item(OP_ACCESS, 32'h0800_0102, 32'h0800_0102, 1'b1, cyc_t'(4));
    // Zero-cost fetch with zero access cycles: nothing consumed.
    send_item(OP_ACCESS, 32'h0300_0000, 32'h0800_0102, 1'b1, cyc_t'(0));
    // Fetch past the top of ROM, then wait on it.
    send_item(OP_ACCESS, 32'h0EFF_FFFE, 32'h0EFF_FFFE, 1'b0, cyc_t'(2));
    send_item(OP_ACCESS, 32'h0400_0000, 32'h0EFF_FFFE, 1'b0, cyc_t'(1));
    send_item(OP_ACCESS, 32'h0F00_0002, 32'h0F00_0002, 1'b0, cyc_t'(1));
    // Fill the buffer to full depth and keep pushing.
    send_item(OP_ACCESS, 32'h0C00_0000, 32'h0C00_0000, 1'b1, cyc_t'(1));
    repeat (9) send_item(OP_ACCESS, 32'h0500_0000, 32'h0C00_0000, 1'b1, cyc_t'(127));
    settle();

    // Random phases across low, high, extreme and random settings, one with prefetch off.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_config(1'b1, wait_t'(2), wait_t'(2), wait_t'(2), wait_t'(2));
        1: program_config(1'b1, wait_t'(9), wait_t'(9), wait_t'(9), wait_t'(9));
        2: program_config(1'b0, wait_t'($urandom_range(2, 9)), wait_t'($urandom_range(2, 9)),
                          wait_t'($urandom_range(2, 9)), wait_t'($urandom_range(2, 9)));
        3: program_config(1'b1, wait_t'(15), wait_t'(0), wait_t'(15), wait_t'(0));
        4: program_config(1'b1, wait_t'($urandom), wait_t'($urandom),
                          wait_t'($urandom), wait_t'($urandom));
        default: program_config(1'b1, wait_t'($urandom_range(2, 9)),
                                wait_t'($urandom_range(2, 9)),
                                wait_t'($urandom_range(2, 9)),
                                wait_t'($urandom_range(2, 9)));
      endcase
      run_program(PHASE_ITEMS);
      settle();
    end

    $display("%0d transactions over %0d register settings, %0d served from the buffer",
             items_sent, settings, hits);
    if (errors == 0) begin
      $display("rom_prefetch_buffer test passed");
    end else begin
      $display("%0d timing mismatches", errors);
      $display("rom_prefetch_buffer test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rpb_pkg.sv
sv/rpb_cell.sv
sv/rpb_ctrl.sv
sv/rom_prefetch_buffer.sv
sim/rpb_timing_checker.sv
sim/tb.sv
